// File: rtl/core/lfa_pkg.sv
// Shared constants, types and codes of the lowest-free number allocator.
`timescale 1ns / 1ps
`default_nettype none

package lfa_pkg;

   localparam int CAPACITY   = 256;
   localparam int NUM_W      = 8;
   localparam int CNT_W      = 9;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int WORD_CNT   = CAPACITY / WORD_W;
   localparam int WADDR_W    = NUM_W - BIT_W;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   typedef struct packed {
      logic               rd_en;
      logic [WADDR_W-1:0] rd_addr;
      logic               wr_en;
      logic [WADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] index;
   } search_type;

endpackage

`default_nettype wire

// File: rtl/core/lfa_if.sv
// Channel interfaces of the allocator: request, response and limit register write.
`timescale 1ns / 1ps
`default_nettype none

interface lfa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [lfa_pkg::NUM_W-1:0] release_number;

   modport source (output valid, output op, output release_number, input ready);
   modport sink   (input valid, input op, input release_number, output ready);
endinterface

interface lfa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      ok;
   logic [lfa_pkg::NUM_W-1:0] granted_number;

   modport source (output valid, output ok, output granted_number, input ready);
   modport sink   (input valid, input ok, input granted_number, output ready);
endinterface

interface lfa_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lfa_pkg::CNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lfa_bitmap.sv
// In-use bitmap memory, one word per row, with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lfa_bitmap (
   input  wire logic                         clock,
   input  wire lfa_pkg::mem_req_type         mem_req,
   output logic [lfa_pkg::WORD_W-1:0]        rd_data
);

   logic [lfa_pkg::WORD_W-1:0] mem [lfa_pkg::WORD_CNT];
   logic [lfa_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/lfa_word_search.sv
// Finds the lowest clear bit of one bitmap word inside the window [start, bound).
`timescale 1ns / 1ps
`default_nettype none

module lfa_word_search (
   input  wire logic [lfa_pkg::WORD_W-1:0]  word,
   input  wire logic [lfa_pkg::WADDR_W-1:0] word_addr,
   input  wire logic [lfa_pkg::CNT_W-1:0]   start,
   input  wire logic [lfa_pkg::CNT_W-1:0]   bound,
   output lfa_pkg::search_type              result
);

   logic [lfa_pkg::WORD_W-1:0] qualify;

   always_comb begin
      logic [lfa_pkg::CNT_W-1:0] pos;
      for (int i = 0; i < lfa_pkg::WORD_W; i++) begin
         pos = {1'b0, word_addr, lfa_pkg::BIT_W'(i)};
         qualify[i] = (pos >= start) && (pos < bound) && !word[i];
      end
   end

   // Priority encoder: the lowest qualifying bit wins.
   always_comb begin
      result.found = |qualify;
      result.index = '0;
      for (int i = lfa_pkg::WORD_W - 1; i >= 0; i--) begin
         if (qualify[i]) begin
            result.index = lfa_pkg::BIT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lowest_free_id_allocator.sv
// Top level of the lowest-free number allocator: control, pointers and response register.
`timescale 1ns / 1ps
`default_nettype none

// Hands out the lowest free number below the programmed limit (clamped to 256) and takes
// numbers back. A failed allocate or release is answered and leaves the block idle. A release
// that succeeds does a read and then a write of its bitmap word. An allocate that succeeds
// reads and rewrites the word of the granted number, then walks further 32-bit bitmap words
// until the scan finds the next free number or reaches its window's end, reading one word per
// cycle. The response sits in an output register, and a new request is taken only while the
// block is idle and that register is empty or its beat is taken in the same cycle, so a
// response left waiting stalls the input. The bitmap needs no clearing pass after reset.
module lowest_free_id_allocator (
   input  wire logic   clock,
   input  wire logic   reset,
   lfa_req_if.sink     req_ch,
   lfa_rsp_if.source   rsp_ch,
   lfa_csr_if.sink     csr_ch
);

   localparam logic [lfa_pkg::CNT_W-1:0] CAP_VALUE  = lfa_pkg::CNT_W'(lfa_pkg::CAPACITY);
   localparam logic [lfa_pkg::CNT_W-1:0] WORD_SPAN  = lfa_pkg::CNT_W'(lfa_pkg::WORD_W);

   lfa_pkg::state_type              state_ff, state_in;
   logic [lfa_pkg::CNT_W-1:0]       created_ff, created_in;
   logic [lfa_pkg::CNT_W-1:0]       lowest_ff, lowest_in;
   logic [lfa_pkg::CNT_W-1:0]       limit_ff, limit_in;
   logic [lfa_pkg::CNT_W-1:0]       start_ff, start_in;
   logic [lfa_pkg::CNT_W-1:0]       bound_ff, bound_in;
   logic [lfa_pkg::WADDR_W-1:0]     waddr_ff, waddr_in;
   logic [lfa_pkg::BIT_W-1:0]       bit_ff, bit_in;
   logic                            first_ff, first_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [lfa_pkg::NUM_W-1:0]       rsp_num_ff, rsp_num_in;

   lfa_pkg::mem_req_type            mem_req;
   logic [lfa_pkg::WORD_W-1:0]      rd_data;
   logic [lfa_pkg::WORD_W-1:0]      scan_word;
   lfa_pkg::search_type             search;

   logic [lfa_pkg::CNT_W-1:0]       eff_limit;
   logic [lfa_pkg::CNT_W-1:0]       created_next;
   logic [lfa_pkg::CNT_W-1:0]       rel_num;
   logic [lfa_pkg::CNT_W-1:0]       next_base;
   logic [lfa_pkg::WORD_W-1:0]      bit_mask;
   logic                            req_fire;
   logic                            alloc_ok;
   logic                            rel_ok;

   lfa_bitmap u_bitmap (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   lfa_word_search u_search (
      .word      (scan_word),
      .word_addr (waddr_ff),
      .start     (start_ff),
      .bound     (bound_ff),
      .result    (search)
   );

   assign eff_limit    = (limit_ff > CAP_VALUE) ? CAP_VALUE : limit_ff;
   assign rel_num      = {1'b0, req_ch.release_number};
   assign alloc_ok     = (lowest_ff < eff_limit) && (lowest_ff <= created_ff);
   assign rel_ok       = rel_num < created_ff;
   assign created_next = (lowest_ff == created_ff) ? created_ff + 1'b1 : created_ff;
   assign bit_mask     = lfa_pkg::WORD_W'(1) << bit_ff;
   assign next_base    = {1'b0, waddr_ff, lfa_pkg::BIT_W'(0)} + WORD_SPAN;

   // The first word of an allocate scan still has the granted bit clear in memory.
   assign scan_word    = first_ff ? (rd_data | bit_mask) : rd_data;

   assign req_ch.ready = (state_ff == lfa_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.ok             = rsp_ok_ff;
   assign rsp_ch.granted_number = rsp_num_ff;

   always_comb begin
      state_in     = state_ff;
      created_in   = created_ff;
      lowest_in    = lowest_ff;
      limit_in     = limit_ff;
      start_in     = start_ff;
      bound_in     = bound_ff;
      waddr_in     = waddr_ff;
      bit_in       = bit_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_num_in   = rsp_num_ff;
      mem_req      = '0;

      if (csr_ch.valid) begin
         limit_in = csr_ch.data;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = '0;
               if (req_ch.op == lfa_pkg::OP_ALLOC) begin
                  rsp_ok_in = alloc_ok;
                  if (alloc_ok) begin
                     rsp_num_in      = lowest_ff[lfa_pkg::NUM_W-1:0];
                     created_in      = created_next;
                     start_in        = lowest_ff + 1'b1;
                     bound_in        = (eff_limit < created_next) ? eff_limit : created_next;
                     waddr_in        = lowest_ff[lfa_pkg::NUM_W-1:lfa_pkg::BIT_W];
                     bit_in          = lowest_ff[lfa_pkg::BIT_W-1:0];
                     first_in        = 1'b1;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = lowest_ff[lfa_pkg::NUM_W-1:lfa_pkg::BIT_W];
                     state_in        = lfa_pkg::ST_SCAN;
                  end
               end else begin
                  rsp_ok_in = rel_ok;
                  if (rel_ok) begin
                     lowest_in       = (rel_num < lowest_ff) ? rel_num : lowest_ff;
                     waddr_in        = req_ch.release_number[lfa_pkg::NUM_W-1:lfa_pkg::BIT_W];
                     bit_in          = req_ch.release_number[lfa_pkg::BIT_W-1:0];
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = req_ch.release_number[lfa_pkg::NUM_W-1:lfa_pkg::BIT_W];
                     state_in        = lfa_pkg::ST_CLEAR;
                  end
               end
            end
         end

         lfa_pkg::ST_SCAN: begin
            if (first_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = waddr_ff;
               mem_req.wr_data = scan_word;
            end
            first_in = 1'b0;
            if (search.found) begin
               lowest_in = {1'b0, waddr_ff, search.index};
               state_in  = lfa_pkg::ST_IDLE;
            end else if (next_base >= bound_ff) begin
               // Nothing free below the window's end: the pointer parks on it.
               lowest_in = bound_ff;
               state_in  = lfa_pkg::ST_IDLE;
            end else begin
               waddr_in        = waddr_ff + 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = waddr_ff + 1'b1;
            end
         end

         lfa_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = waddr_ff;
            mem_req.wr_data = rd_data & ~bit_mask;
            state_in        = lfa_pkg::ST_IDLE;
         end

         default: begin
            state_in = lfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfa_pkg::ST_IDLE;
         created_ff   <= '0;
         lowest_ff    <= '0;
         limit_ff     <= CAP_VALUE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         created_ff   <= created_in;
         lowest_ff    <= lowest_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      bound_ff   <= bound_in;
      waddr_ff   <= waddr_in;
      bit_ff     <= bit_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_num_ff <= rsp_num_in;
   end

   // The pointer never passes the high-water mark.
   assert property (@(posedge clock) disable iff (reset) lowest_ff <= created_ff)
      else $error("lowest free pointer above created count");

   assert property (@(posedge clock) disable iff (reset) created_ff <= CAP_VALUE)
      else $error("created count above capacity");

   // A read and a write in the same cycle never touch the same bitmap word.
   assert property (@(posedge clock) disable iff (reset)
      (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
      else $error("bitmap read and write collide on one word");

   // A successful release always goes on to write its word back.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.op == lfa_pkg::OP_RELEASE) && rel_ok)
         |=> (state_ff == lfa_pkg::ST_CLEAR))
      else $error("release did not enter the clear step");

   // No new request is taken while a scan is still moving the pointer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfa_pkg::ST_SCAN) |-> !req_ch.ready)
      else $error("request ready during scan");

endmodule

`default_nettype wire
